>>> design/ihs_pkg.sv
// Shared types and constants for the image header size sniffer.
// Holds format and status codes, magic values and the result record.
// No dependencies.
`timescale 1ns / 1ps

package ihs_pkg;

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_BAD_JPEG  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [31:0] PNG_MAGIC     = 32'h8950_4E47;
  localparam logic [15:0] JPEG_SOI      = 16'hFFD8;
  localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
  localparam logic [7:0]  SOF0          = 8'hC0;
  localparam logic [7:0]  SOF1          = 8'hC1;
  localparam logic [7:0]  SOF2          = 8'hC2;
  localparam logic [7:0]  SOF3          = 8'hC3;

  localparam logic [4:0] MAGIC_LEN     = 5'd4;
  localparam logic [4:0] PNG_DIM_START = 5'd16;
  localparam logic [4:0] PNG_DIM_END   = 5'd24;
  localparam logic [4:0] JPEG_DIM_LEN  = 5'd4;
  localparam logic [15:0] SOF_PAD      = 16'd3;
  localparam logic [15:0] MIN_SEG_LEN  = 16'd2;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] width;
    logic [31:0] height;
    logic [1:0]  status;
  } result_t;

endpackage

>>> design/ihs_parser.sv
// Byte-wise header parser: holds the parse state and forms at most one
// result per accepted byte, combinationally. Depends on ihs_pkg.
`timescale 1ns / 1ps

module ihs_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             res_valid_o,
  output ihs_pkg::result_t res_o
);

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_PNG,
    PH_MARK0,
    PH_MARK1,
    PH_LEN0,
    PH_LEN1,
    PH_SKIP,
    PH_SOFSKIP,
    PH_DIM,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  off_q, off_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] skip_q, skip_d;
  logic [63:0] shift_q, shift_d;

  logic        hit;
  logic [4:0]  off_inc;
  logic [31:0] magic_nxt;
  logic [63:0] png_shift;
  logic [31:0] dim_shift;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        is_sof;

  assign off_inc   = off_q + 5'd1;
  assign magic_nxt = {magic_q[23:0], data_byte_i};
  assign png_shift = (off_q >= ihs_pkg::PNG_DIM_START) ? {shift_q[55:0], data_byte_i}
                                                       : shift_q;
  assign dim_shift = {shift_q[23:0], data_byte_i};
  assign seg_len   = skip_q | {8'h00, data_byte_i};
  assign skip_dec  = skip_q - 16'd1;
  assign is_sof    = data_byte_i inside {ihs_pkg::SOF0, ihs_pkg::SOF1,
                                         ihs_pkg::SOF2, ihs_pkg::SOF3};

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    magic_d = magic_q;
    skip_d  = skip_q;
    shift_d = shift_q;
    hit     = 1'b0;
    res_o   = '0;

    case (phase_q)
      PH_MAGIC: begin
        magic_d = magic_nxt;
        off_d   = off_inc;
        if (off_inc >= ihs_pkg::MAGIC_LEN) begin
          if (magic_nxt == ihs_pkg::PNG_MAGIC) begin
            phase_d = PH_PNG;
          end else if (magic_nxt[31:16] == ihs_pkg::JPEG_SOI) begin
            // bytes 2 and 3 start the marker walk in the same cycle
            if (magic_nxt[15:8] != ihs_pkg::MARKER_PREFIX) begin
              hit         = 1'b1;
              res_o.fmt   = ihs_pkg::FMT_JPEG;
              res_o.status = ihs_pkg::ST_BAD_JPEG;
              phase_d     = PH_DONE;
            end else if (is_sof) begin
              skip_d  = ihs_pkg::SOF_PAD;
              phase_d = PH_SOFSKIP;
            end else begin
              phase_d = PH_LEN0;
            end
          end else begin
            hit          = 1'b1;
            res_o.fmt    = ihs_pkg::FMT_NONE;
            res_o.status = ihs_pkg::ST_UNKNOWN;
            phase_d      = PH_DONE;
          end
        end
      end
      PH_PNG: begin
        shift_d = png_shift;
        off_d   = off_inc;
        if (off_inc >= ihs_pkg::PNG_DIM_END) begin
          hit          = 1'b1;
          res_o.fmt    = ihs_pkg::FMT_PNG;
          res_o.width  = png_shift[63:32];
          res_o.height = png_shift[31:0];
          res_o.status = ihs_pkg::ST_OK;
          phase_d      = PH_DONE;
        end
      end
      PH_MARK0: begin
        if (data_byte_i != ihs_pkg::MARKER_PREFIX) begin
          hit          = 1'b1;
          res_o.fmt    = ihs_pkg::FMT_JPEG;
          res_o.status = ihs_pkg::ST_BAD_JPEG;
          phase_d      = PH_DONE;
        end else begin
          phase_d = PH_MARK1;
        end
      end
      PH_MARK1: begin
        if (is_sof) begin
          skip_d  = ihs_pkg::SOF_PAD;
          phase_d = PH_SOFSKIP;
        end else begin
          phase_d = PH_LEN0;
        end
      end
      PH_LEN0: begin
        skip_d  = {data_byte_i, 8'h00};
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        if (seg_len < ihs_pkg::MIN_SEG_LEN) begin
          hit          = 1'b1;
          res_o.fmt    = ihs_pkg::FMT_JPEG;
          res_o.status = ihs_pkg::ST_BAD_JPEG;
          phase_d      = PH_DONE;
        end else begin
          skip_d  = seg_len - ihs_pkg::MIN_SEG_LEN;
          phase_d = (seg_len == ihs_pkg::MIN_SEG_LEN) ? PH_MARK0 : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = PH_MARK0;
        end
      end
      PH_SOFSKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          off_d   = 5'd0;
          shift_d = '0;
          phase_d = PH_DIM;
        end
      end
      PH_DIM: begin
        shift_d = {32'h0, dim_shift};
        off_d   = off_inc;
        if (off_inc >= ihs_pkg::JPEG_DIM_LEN) begin
          hit          = 1'b1;
          res_o.fmt    = ihs_pkg::FMT_JPEG;
          res_o.width  = {16'h0, dim_shift[15:0]};
          res_o.height = {16'h0, dim_shift[31:16]};
          res_o.status = ihs_pkg::ST_OK;
          phase_d      = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (last_byte_i) begin
      if (!hit && (phase_q != PH_DONE)) begin
        hit          = 1'b1;
        res_o        = '0;
        res_o.status = ihs_pkg::ST_TRUNCATED;
        case (phase_d)
          PH_MAGIC: res_o.fmt = ihs_pkg::FMT_NONE;
          PH_PNG:   res_o.fmt = ihs_pkg::FMT_PNG;
          default:  res_o.fmt = ihs_pkg::FMT_JPEG;
        endcase
      end
      phase_d = PH_MAGIC;
      off_d   = 5'd0;
      magic_d = '0;
      skip_d  = '0;
      shift_d = '0;
    end
  end

  assign res_valid_o = byte_valid_i & hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      off_q   <= 5'd0;
      magic_q <= '0;
      skip_q  <= '0;
      shift_q <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      magic_q <= magic_d;
      skip_q  <= skip_d;
      shift_q <= shift_d;
    end
  end

`ifndef SYNTHESIS
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && last_byte_i |=> phase_q == PH_MAGIC && off_q == 5'd0)
    else $error("parser did not re-arm after last byte");

  a_quiet_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && !last_byte_i && phase_q == PH_DONE |-> !res_valid_o)
    else $error("result after decision");

  a_done_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_byte_i |=> phase_q == PH_DONE)
    else $error("result given without reaching done");
`endif

endmodule

>>> design/image_header_size_sniffer.sv
// Image header size sniffer: PNG/JPEG dimension parser with a buffered
// result channel. Depends on ihs_pkg and ihs_parser.
`timescale 1ns / 1ps

// One byte is taken per cycle, sustained, and each byte updates the parse
// state in that same cycle; the single result of a file is registered on
// the output from the byte that decides it (or the last byte).
// A result register plus one skid entry sit on the output, so input keeps
// flowing while a result waits; input stalls only when both are full.
// The rate is set by the parse state update per accepted byte. Reset is
// asynchronous, active low, and leaves the parser awaiting a file's first
// byte.
module image_header_size_sniffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  format_o,
  output logic [31:0] width_o,
  output logic [31:0] height_o,
  output logic [1:0]  status_o
);

  logic             accept;
  logic             res_valid;
  ihs_pkg::result_t res;

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  ihs_pkg::result_t out_q, out_d;
  ihs_pkg::result_t skid_q, skid_d;
  logic             out_free;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i & in_ready_o;

  ihs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign format_o    = out_q.fmt;
  assign width_o     = out_q.width;
  assign height_o    = out_q.height;
  assign status_o    = out_q.status;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_valid_q ##1 skid_valid_q |-> $past(out_valid_q && !out_ready_i && res_valid))
    else $error("skid filled without an output stall");

  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && out_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("result lost on stalled output");
`endif

endmodule

>>> verif/testbench.sv
// Testbench for image_header_size_sniffer: streams PNG/JPEG files byte by byte
// and checks each dimension result against an in-bench header parser.
// Depends on ihs_pkg and the image_header_size_sniffer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [3:0] {
    P_MAGIC, P_PNG, P_MARK0, P_MARK1, P_LEN0, P_LEN1, P_SKIP, P_SOFSKIP, P_DIM, P_DONE
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  format_o;
  logic [31:0] width_o;
  logic [31:0] height_o;
  logic [1:0]  status_o;

  image_header_size_sniffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .format_o    (format_o),
    .width_o     (width_o),
    .height_o    (height_o),
    .status_o    (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // header parser state
  parse_phase_e phase_q;
  logic [4:0]   offs_q;
  logic [31:0]  magic_q;
  logic [15:0]  skip_q;
  logic [63:0]  shift_q;
  logic         given_q;

  ihs_pkg::result_t pending_dims_q[$];
  logic [7:0]  file_q[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  function automatic void clear_parser();
    phase_q = P_MAGIC;
    offs_q  = '0;
    magic_q = '0;
    skip_q  = '0;
    shift_q = '0;
    given_q = 1'b0;
  endfunction

  function automatic ihs_pkg::result_t close_file(logic [1:0] fmt, logic [31:0] w,
                                                  logic [31:0] h, logic [1:0] st);
    ihs_pkg::result_t r;
    r.fmt    = fmt;
    r.width  = w;
    r.height = h;
    r.status = st;
    phase_q  = P_DONE;
    given_q  = 1'b1;
    return r;
  endfunction

  function automatic bit walk_jpeg(input logic [7:0] b, output ihs_pkg::result_t r);
    logic [15:0] seg_len;
    walk_jpeg = 1'b0;
    r = '0;
    case (phase_q)
      P_MARK0: begin
        if (b != ihs_pkg::MARKER_PREFIX) begin
          r = close_file(ihs_pkg::FMT_JPEG, '0, '0, ihs_pkg::ST_BAD_JPEG);
          walk_jpeg = 1'b1;
        end else begin
          phase_q = P_MARK1;
        end
      end
      P_MARK1: begin
        if (b inside {ihs_pkg::SOF0, ihs_pkg::SOF1, ihs_pkg::SOF2, ihs_pkg::SOF3}) begin
          skip_q  = ihs_pkg::SOF_PAD;
          phase_q = P_SOFSKIP;
        end else begin
          phase_q = P_LEN0;
        end
      end
      P_LEN0: begin
        skip_q  = {b, 8'h00};
        phase_q = P_LEN1;
      end
      P_LEN1: begin
        seg_len = skip_q | {8'h00, b};
        if (seg_len < ihs_pkg::MIN_SEG_LEN) begin
          r = close_file(ihs_pkg::FMT_JPEG, '0, '0, ihs_pkg::ST_BAD_JPEG);
          walk_jpeg = 1'b1;
        end else begin
          skip_q  = seg_len - ihs_pkg::MIN_SEG_LEN;
          phase_q = (skip_q == '0) ? P_MARK0 : P_SKIP;
        end
      end
      P_SKIP: begin
        skip_q--;
        if (skip_q == '0) phase_q = P_MARK0;
      end
      P_SOFSKIP: begin
        skip_q--;
        if (skip_q == '0) begin
          offs_q  = '0;
          shift_q = '0;
          phase_q = P_DIM;
        end
      end
      P_DIM: begin
        shift_q = {32'h0, shift_q[23:0], b};
        offs_q++;
        if (offs_q >= ihs_pkg::JPEG_DIM_LEN) begin
          r = close_file(ihs_pkg::FMT_JPEG, {16'h0, shift_q[15:0]}, {16'h0, shift_q[31:16]},
                         ihs_pkg::ST_OK);
          walk_jpeg = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void sniff_byte(logic [7:0] b, logic is_last);
    ihs_pkg::result_t r;
    bit          got;
    logic [1:0]  fmt;
    got = 1'b0;
    r = '0;
    case (phase_q)
      P_MAGIC: begin
        magic_q = {magic_q[23:0], b};
        offs_q++;
        if (offs_q >= ihs_pkg::MAGIC_LEN) begin
          if (magic_q == ihs_pkg::PNG_MAGIC) begin
            phase_q = P_PNG;
          end else if (magic_q[31:16] == ihs_pkg::JPEG_SOI) begin
            phase_q = P_MARK0;
            got = walk_jpeg(magic_q[15:8], r);
            if (!got) got = walk_jpeg(magic_q[7:0], r);
          end else begin
            r = close_file(ihs_pkg::FMT_NONE, '0, '0, ihs_pkg::ST_UNKNOWN);
            got = 1'b1;
          end
        end
      end
      P_PNG: begin
        if (offs_q >= ihs_pkg::PNG_DIM_START) shift_q = {shift_q[55:0], b};
        offs_q++;
        if (offs_q >= ihs_pkg::PNG_DIM_END) begin
          r = close_file(ihs_pkg::FMT_PNG, shift_q[63:32], shift_q[31:0], ihs_pkg::ST_OK);
          got = 1'b1;
        end
      end
      P_DONE: ;
      default: got = walk_jpeg(b, r);
    endcase
    if (is_last) begin
      if (!got && !given_q) begin
        fmt = (phase_q == P_MAGIC) ? ihs_pkg::FMT_NONE :
              (phase_q == P_PNG) ? ihs_pkg::FMT_PNG : ihs_pkg::FMT_JPEG;
        r = close_file(fmt, '0, '0, ihs_pkg::ST_TRUNCATED);
        got = 1'b1;
      end
      clear_parser();
    end
    if (got) pending_dims_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_dims();
    ihs_pkg::result_t want;
    if (pending_dims_q.size() == 0) begin
      report_mismatch("result with none pending", {30'h0, format_o}, '0);
      return;
    end
    want = pending_dims_q.pop_front();
    if (format_o !== want.fmt) report_mismatch("format", {30'h0, format_o}, {30'h0, want.fmt});
    if (width_o !== want.width) report_mismatch("width", width_o, want.width);
    if (height_o !== want.height) report_mismatch("height", height_o, want.height);
    if (status_o !== want.status)
      report_mismatch("status", {30'h0, status_o}, {30'h0, want.status});
  endtask

  // input prediction first, then result check, both from pre-edge values
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sniff_byte(data_byte_i, last_byte_i);
    if (out_valid_o && out_ready_i) check_dims();
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dims_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void put_u32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_u16(logic [15:0] v);
    file_q.push_back(v[15:8]);
    file_q.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_soi();
    put_u16(ihs_pkg::JPEG_SOI);
  endfunction

  task automatic test_png_headers();
    put_u32(ihs_pkg::PNG_MAGIC); put_random(12); put_u32(32'hFFFF_FFFF); put_u32(32'h0);
    put_random(3);
    send_file();
    put_u32(ihs_pkg::PNG_MAGIC); put_random(12); put_u32(32'h0); put_u32(32'hFFFF_FFFF);
    send_file();
    put_u32(ihs_pkg::PNG_MAGIC); put_random(12); put_u32($urandom); put_u32($urandom);
    put_random(1);
    send_file();
    put_u32(ihs_pkg::PNG_MAGIC); put_random(10);
    send_file();
  endtask

  task automatic test_jpeg_headers();
    logic [15:0] h;
    logic [15:0] w;
    for (int s = 0; s < 4; s++) begin
      h = (s == 0) ? 16'hFFFF : (s == 1) ? 16'h0000 : 16'($urandom);
      w = (s == 0) ? 16'h0000 : (s == 1) ? 16'hFFFF : 16'($urandom);
      put_soi();
      file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(8'hE0);
      put_u16(ihs_pkg::MIN_SEG_LEN);
      file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(ihs_pkg::SOF0 + 8'(s));
      put_random(3); put_u16(h); put_u16(w);
      if (s != 3) put_random(2);
      send_file();
    end
    // fill byte as marker, then a marker with an empty body, then SOF
    put_soi();
    file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(ihs_pkg::MARKER_PREFIX);
    put_u16(16'd5);
    put_random(3);
    file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(8'h01); put_u16(16'd2);
    file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(ihs_pkg::SOF2);
    put_random(7);
    send_file();
  endtask

  task automatic test_jpeg_errors();
    put_soi(); file_q.push_back(8'h00); put_random(4);
    send_file();
    put_soi(); file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(8'hE1);
    put_u16(16'd0);
    put_random(2);
    send_file();
    put_soi(); file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(8'hE1);
    put_u16(16'd1);
    send_file();
    put_soi(); file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(8'hDB);
    put_u16(16'd4);
    put_random(2); file_q.push_back(8'h12); put_random(1);
    send_file();
    put_soi(); file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(ihs_pkg::SOF1);
    put_random(2);
    send_file();
  endtask

  task automatic test_unknown_and_short();
    put_u32(32'h0); put_random(2);
    send_file();
    put_u32(32'hFFFF_FFFF);
    send_file();
    file_q.push_back(8'hFF);
    send_file();
    put_u16(16'h8950); file_q.push_back(8'h4E);
    send_file();
    put_u32(32'h8950_4E46);
    send_file();
    put_soi();
    send_file();
    put_soi(); file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(ihs_pkg::SOF0);
    send_file();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) begin
      file_q.push_back(8'h00); put_random(3);
      send_file();
    end
    wait_drained();
  endtask

  task automatic test_random_files(input int n_bytes, input int src_pct, input int snk_pct);
    int          start;
    int          cut;
    int          seg_len;
    logic [7:0]  m;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          put_u32(ihs_pkg::PNG_MAGIC); put_random(20); put_random($urandom_range(4));
        end
        4, 5, 6, 7: begin
          put_soi();
          repeat ($urandom_range(3)) begin
            m = 8'($urandom_range(255));
            if (m inside {ihs_pkg::SOF0, ihs_pkg::SOF1, ihs_pkg::SOF2, ihs_pkg::SOF3})
              m ^= 8'h10;
            seg_len = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
            file_q.push_back(ihs_pkg::MARKER_PREFIX); file_q.push_back(m);
            put_u16(16'(seg_len));
            if (seg_len >= 2) put_random(seg_len - 2);
          end
          if ($urandom_range(9) == 0) file_q.push_back(8'($urandom_range(254)));
          file_q.push_back(ihs_pkg::MARKER_PREFIX);
          file_q.push_back(ihs_pkg::SOF0 + 8'($urandom_range(3)));
          put_random(7 + $urandom_range(3));
        end
        default: begin
          if ($urandom_range(1)) file_q.push_back(ihs_pkg::MARKER_PREFIX);
          put_random($urandom_range(1, 8));
        end
      endcase
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(file_q.size(), 1);
        while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
      end
      send_file();
    end
    wait_drained();
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_png_headers();
    test_jpeg_headers();
    test_jpeg_errors();
    test_unknown_and_short();
    wait_drained();
    test_output_backpressure();
    test_random_files(300, 0, 0);
    test_random_files(300, 64, 0);
    test_random_files(300, 0, 64);
    test_random_files(300, 38, 38);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_dims_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
